@@ design/pyd_pkg.sv @@
// ----------------------------------------------------------------------------
// pyd_pkg: shared types and constants for the pointer yaw/pitch direction block
// Defaults, register and function codes, CORDIC formats and the arctangent
// steps used by the rotation cells.
// ----------------------------------------------------------------------------
package pyd_pkg;

  localparam int DEF_ANGLE_FRAC_BITS = 10;
  localparam int DEF_COORD_BITS      = 16;
  localparam int DEF_DIR_FRAC_BITS   = 14;

  localparam int SENS_W      = 12;
  localparam int LIMIT_W     = 17;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 17;

  localparam logic [SENS_W-1:0] SENS_RESET = 12'd635;

  // CORDIC formats: angle in 2^-20 degree, x/y in Q30
  localparam int CORDIC_STEPS    = 20;
  localparam int CORDIC_ANG_FRAC = 20;
  localparam int CORDIC_W        = 32;
  localparam int Z_W             = 30;

  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 32'sd652032874;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SENSITIVITY = 1'b0,
    REG_PITCH_LIMIT = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    FUNC_POINTER    = 1'b0,
    FUNC_FACE_FRONT = 1'b1
  } func_t;

  typedef struct packed {
    logic signed [CORDIC_W-1:0] x;
    logic signed [CORDIC_W-1:0] y;
    logic signed [Z_W-1:0]      z;
  } rot_t;

  function automatic logic signed [Z_W-1:0] atan_step(input int unsigned i);
    case (i)
      0:       return 30'sd47185920;
      1:       return 30'sd27855475;
      2:       return 30'sd14718068;
      3:       return 30'sd7471121;
      4:       return 30'sd3750058;
      5:       return 30'sd1876857;
      6:       return 30'sd938658;
      7:       return 30'sd469357;
      8:       return 30'sd234682;
      9:       return 30'sd117342;
      10:      return 30'sd58671;
      11:      return 30'sd29335;
      12:      return 30'sd14668;
      13:      return 30'sd7334;
      14:      return 30'sd3667;
      15:      return 30'sd1833;
      16:      return 30'sd917;
      17:      return 30'sd458;
      18:      return 30'sd229;
      19:      return 30'sd115;
      default: return '0;
    endcase
  endfunction

endpackage

@@ design/pyd_mod_cell.sv @@
// ----------------------------------------------------------------------------
// pyd_mod_cell: one step of the yaw wrap chain
// Subtracts a fixed multiple of the full turn when the value reaches it and
// hands the remainder to the next cell.
// ----------------------------------------------------------------------------
module pyd_mod_cell #(
  parameter int            R_W = 30,
  parameter logic [R_W-1:0] SUB = '0
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           valid_in,
  input  logic [R_W-1:0] r_in,
  output logic           valid_out,
  output logic [R_W-1:0] r_out
);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    r_out <= (r_in >= SUB) ? (r_in - SUB) : r_in;
  end

endmodule

@@ design/pyd_cordic_cell.sv @@
// ----------------------------------------------------------------------------
// pyd_cordic_cell: one CORDIC rotation step for the yaw and pitch lanes
// Rotates both vectors toward their residual angles by the arctangent of
// 2^-STEP and hands them to the next cell.
// ----------------------------------------------------------------------------
module pyd_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          valid_in,
  input  pyd_pkg::rot_t yaw_in,
  input  pyd_pkg::rot_t pitch_in,
  output logic          valid_out,
  output pyd_pkg::rot_t yaw_out,
  output pyd_pkg::rot_t pitch_out
);
  import pyd_pkg::*;

  localparam logic signed [Z_W-1:0] ANGLE = atan_step(STEP);

  function automatic rot_t rotate(input rot_t r);
    rot_t                       n;
    logic signed [CORDIC_W-1:0] dx;
    logic signed [CORDIC_W-1:0] dy;
    dx = $signed(r.y) >>> STEP;
    dy = $signed(r.x) >>> STEP;
    if (!r.z[Z_W-1]) begin
      n.x = r.x - dx;
      n.y = r.y + dy;
      n.z = r.z - ANGLE;
    end else begin
      n.x = r.x + dx;
      n.y = r.y - dy;
      n.z = r.z + ANGLE;
    end
    return n;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    yaw_out   <= rotate(yaw_in);
    pitch_out <= rotate(pitch_in);
  end

endmodule

@@ design/pointer_yaw_pitch_direction_top.sv @@
// ----------------------------------------------------------------------------
// pointer_yaw_pitch_direction_top: pointer-driven yaw/pitch to direction vector
// Pointer beat: delta, product and sum registers, W yaw wrap cells (11 by default),
//   the CORDIC load register, the 20-cell CORDIC row, then the f, p and output registers.
//   Face front beat: p register, then output. New beats wait for an empty pipeline.
// Reset (rst, synchronous): registers to defaults, yaw 270, pitch 0, first sample
//   pending, pipeline and output empty.
// ----------------------------------------------------------------------------
module pointer_yaw_pitch_direction_top #(
  parameter int ANGLE_FRAC_BITS = pyd_pkg::DEF_ANGLE_FRAC_BITS,
  parameter int COORD_BITS      = pyd_pkg::DEF_COORD_BITS,
  parameter int DIR_FRAC_BITS   = pyd_pkg::DEF_DIR_FRAC_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [pyd_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [pyd_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                func,
  input  logic signed [COORD_BITS-1:0]        mouse_x,
  input  logic signed [COORD_BITS-1:0]        mouse_y,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [DIR_FRAC_BITS+1:0]     view_x,
  output logic signed [DIR_FRAC_BITS+1:0]     view_y,
  output logic signed [DIR_FRAC_BITS+1:0]     view_z
);
  import pyd_pkg::*;

  localparam int D_W     = COORD_BITS + 1;
  localparam int PROD_W  = COORD_BITS + 14;
  localparam int SUM_W   = ((COORD_BITS + 13 > ANGLE_FRAC_BITS + 10) ?
                            COORD_BITS + 13 : ANGLE_FRAC_BITS + 10) + 1;
  localparam int YAW_W   = ANGLE_FRAC_BITS + 9;
  localparam int YF_W    = YAW_W + 1;
  localparam int PITCH_W = ANGLE_FRAC_BITS + 8;
  localparam int LIM_W   = (ANGLE_FRAC_BITS + 7 > LIMIT_W) ? ANGLE_FRAC_BITS + 7 : LIMIT_W;
  localparam int NMOD    = SUM_W - ANGLE_FRAC_BITS - 9;
  localparam int Z_SHIFT = CORDIC_ANG_FRAC - ANGLE_FRAC_BITS;
  localparam int OUT_W   = DIR_FRAC_BITS + 2;
  localparam int XY_SHIFT = 60 - DIR_FRAC_BITS;
  localparam int SP_SHIFT = 30 - DIR_FRAC_BITS;

  localparam int FULL_TURN = 360 << ANGLE_FRAC_BITS;
  localparam int QUARTER   = 90 << ANGLE_FRAC_BITS;

  localparam logic [SUM_W-1:0]   FULL_TURN_S = SUM_W'(FULL_TURN);
  localparam logic [SUM_W-1:0]   WRAP_ADD    = FULL_TURN_S << NMOD;
  localparam logic [YAW_W-1:0]   YAW_RESET   = YAW_W'(270 << ANGLE_FRAC_BITS);
  localparam logic [YAW_W-1:0]   YAW_Q1      = YAW_W'(QUARTER);
  localparam logic [YAW_W-1:0]   YAW_Q3      = YAW_W'(270 << ANGLE_FRAC_BITS);
  localparam logic signed [YF_W-1:0] HALF_TURN_F = YF_W'(180 << ANGLE_FRAC_BITS);
  localparam logic signed [YF_W-1:0] FULL_TURN_F = YF_W'(FULL_TURN);
  localparam logic [LIM_W-1:0]   LIM_MAX     = LIM_W'(QUARTER);
  localparam logic [LIM_W-1:0]   LIM_RESET   = LIM_W'(89 << ANGLE_FRAC_BITS);
  localparam logic signed [OUT_W-1:0] DIR_NEG_ONE = {2'b11, {DIR_FRAC_BITS{1'b0}}};

  // round half up, floor shift, saturate to +/- 1.0
  function automatic logic signed [OUT_W-1:0] round_sat(input logic signed [63:0] v,
                                                        input int unsigned sh);
    logic signed [63:0] half;
    logic signed [63:0] r;
    logic signed [63:0] lim;
    half = $signed((64'd1 << sh) >> 1);
    r    = (v + half) >>> sh;
    lim  = 64'sd1 <<< DIR_FRAC_BITS;
    if (r > lim) begin
      r = lim;
    end else if (r < -lim) begin
      r = -lim;
    end
    return r[OUT_W-1:0];
  endfunction

  // architectural state and registers
  logic                         first_sample;
  logic signed [COORD_BITS-1:0] last_x;
  logic signed [COORD_BITS-1:0] last_y;
  logic [YAW_W-1:0]             yaw_angle;
  logic signed [PITCH_W-1:0]    pitch_angle;
  logic [SENS_W-1:0]            sensitivity;
  logic [LIM_W-1:0]             pitch_limit;

  // pipeline
  logic                      d_valid;
  logic signed [D_W-1:0]     d_x;
  logic signed [D_W-1:0]     d_y;
  logic                      m_valid;
  logic signed [PROD_W-1:0]  m_x;
  logic signed [PROD_W-1:0]  m_y;
  logic                      s_v;
  logic [SUM_W-1:0]          s_r;
  logic [NMOD:0]             mod_v;
  logic [SUM_W-1:0]          mod_r [0:NMOD];
  logic                      c_v;
  logic                      c_neg;
  rot_t                      c_yaw;
  rot_t                      c_pitch;
  logic [CORDIC_STEPS:0]     cord_v;
  rot_t                      cord_yaw   [0:CORDIC_STEPS];
  rot_t                      cord_pitch [0:CORDIC_STEPS];
  logic                      f_valid;
  logic signed [CORDIC_W-1:0] f_cy;
  logic signed [CORDIC_W-1:0] f_sy;
  logic signed [CORDIC_W-1:0] f_cp;
  logic signed [CORDIC_W-1:0] f_sp;
  logic                      p_valid;
  logic                      p_front;
  logic signed [63:0]        p_xx;
  logic signed [63:0]        p_zz;
  logic signed [CORDIC_W-1:0] p_sp;

  // combinational
  logic                         busy;
  logic                         in_fire;
  logic                         front;
  logic                         out_load;
  logic signed [COORD_BITS-1:0] base_x;
  logic signed [COORD_BITS-1:0] base_y;
  logic signed [D_W-1:0]        dx_next;
  logic signed [D_W-1:0]        dy_next;
  logic signed [SUM_W-1:0]      yaw_sum;
  logic [SUM_W-1:0]             yaw_start;
  logic signed [SUM_W-1:0]      pitch_sum;
  logic [LIM_W-1:0]             lim;
  logic signed [SUM_W-1:0]      lim_s;
  logic signed [SUM_W-1:0]      pitch_clamped;
  logic [YAW_W-1:0]             yaw_new;
  logic signed [YF_W-1:0]       yaw_s;
  logic signed [YF_W-1:0]       fold;
  logic                         fold_neg;
  logic signed [Z_W-1:0]        z_yaw;
  logic signed [Z_W-1:0]        z_pitch;

  assign busy     = d_valid | m_valid | (|mod_v) | (|cord_v) | f_valid | p_valid;
  assign in_stall = busy;
  assign in_fire  = in_valid && !in_stall;
  assign front    = (func_t'(func) == FUNC_FACE_FRONT);
  assign out_load = p_valid && (!out_valid || !out_stall);

  // deltas; the first sample compares with itself
  always_comb begin
    base_x  = first_sample ? mouse_x : last_x;
    base_y  = first_sample ? mouse_y : last_y;
    dx_next = D_W'(mouse_x) - D_W'(base_x);
    dy_next = D_W'(base_y) - D_W'(mouse_y);
  end

  // angle update: yaw sum moved into the non-negative range, pitch clamped
  always_comb begin
    yaw_sum   = SUM_W'($signed({1'b0, yaw_angle})) + SUM_W'(m_x);
    yaw_start = yaw_sum[SUM_W-1] ? ($unsigned(yaw_sum) + WRAP_ADD) : $unsigned(yaw_sum);
    pitch_sum = SUM_W'(pitch_angle) + SUM_W'(m_y);
    lim       = (pitch_limit > LIM_MAX) ? LIM_MAX : pitch_limit;
    lim_s     = $signed(SUM_W'(lim));
    if (pitch_sum > lim_s) begin
      pitch_clamped = lim_s;
    end else if (pitch_sum < -lim_s) begin
      pitch_clamped = -lim_s;
    end else begin
      pitch_clamped = pitch_sum;
    end
  end

  // fold yaw into [-90, 90] degrees, remember a half-turn flip
  always_comb begin
    yaw_new = mod_r[NMOD][YAW_W-1:0];
    yaw_s   = $signed({1'b0, yaw_new});
    if (yaw_new <= YAW_Q1) begin
      fold     = yaw_s;
      fold_neg = 1'b0;
    end else if (yaw_new < YAW_Q3) begin
      fold     = yaw_s - HALF_TURN_F;
      fold_neg = 1'b1;
    end else begin
      fold     = yaw_s - FULL_TURN_F;
      fold_neg = 1'b0;
    end
    z_yaw   = Z_W'(fold) <<< Z_SHIFT;
    z_pitch = Z_W'(pitch_angle) <<< Z_SHIFT;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_sample <= 1'b1;
      last_x       <= '0;
      last_y       <= '0;
      yaw_angle    <= YAW_RESET;
      pitch_angle  <= '0;
      sensitivity  <= SENS_RESET;
      pitch_limit  <= LIM_RESET;
      d_valid      <= 1'b0;
      m_valid      <= 1'b0;
      s_v          <= 1'b0;
      c_v          <= 1'b0;
      f_valid      <= 1'b0;
      p_valid      <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_reg_t'(cfg_index))
          REG_SENSITIVITY: sensitivity <= cfg_data[SENS_W-1:0];
          REG_PITCH_LIMIT: pitch_limit <= LIM_W'(cfg_data);
          default: ;
        endcase
      end
      d_valid <= in_fire && !front;
      m_valid <= d_valid;
      s_v     <= m_valid;
      c_v     <= mod_v[NMOD];
      f_valid <= cord_v[CORDIC_STEPS];
      if (in_fire) begin
        if (front) begin
          yaw_angle   <= YAW_RESET;
          pitch_angle <= '0;
        end else begin
          last_x       <= mouse_x;
          last_y       <= mouse_y;
          first_sample <= 1'b0;
        end
      end
      if (m_valid) begin
        pitch_angle <= pitch_clamped[PITCH_W-1:0];
      end
      if (mod_v[NMOD]) begin
        yaw_angle <= yaw_new;
      end
      if (f_valid || (in_fire && front)) begin
        p_valid <= 1'b1;
      end else if (out_load) begin
        p_valid <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      d_x <= dx_next;
      d_y <= dy_next;
    end
    if (d_valid) begin
      m_x <= PROD_W'(d_x) * PROD_W'($signed({1'b0, sensitivity}));
      m_y <= PROD_W'(d_y) * PROD_W'($signed({1'b0, sensitivity}));
    end
    if (m_valid) begin
      s_r <= yaw_start;
    end
    if (mod_v[NMOD]) begin
      c_neg   <= fold_neg;
      c_yaw   <= '{x: CORDIC_GAIN, y: '0, z: z_yaw};
      c_pitch <= '{x: CORDIC_GAIN, y: '0, z: z_pitch};
    end
    if (cord_v[CORDIC_STEPS]) begin
      f_cy <= c_neg ? -cord_yaw[CORDIC_STEPS].x : cord_yaw[CORDIC_STEPS].x;
      f_sy <= c_neg ? -cord_yaw[CORDIC_STEPS].y : cord_yaw[CORDIC_STEPS].y;
      f_cp <= cord_pitch[CORDIC_STEPS].x;
      f_sp <= cord_pitch[CORDIC_STEPS].y;
    end
    if (f_valid) begin
      p_xx    <= f_cy * f_cp;
      p_zz    <= f_sy * f_cp;
      p_sp    <= f_sp;
      p_front <= 1'b0;
    end else if (in_fire && front) begin
      p_front <= 1'b1;
    end
    if (out_load) begin
      if (p_front) begin
        view_x <= '0;
        view_y <= '0;
        view_z <= DIR_NEG_ONE;
      end else begin
        view_x <= round_sat(p_xx, XY_SHIFT);
        view_y <= round_sat(64'(p_sp), SP_SHIFT);
        view_z <= round_sat(p_zz, XY_SHIFT);
      end
    end
  end

  // yaw wrap chain: one conditional subtract of the turn times 2^k per cell
  assign mod_v[0] = s_v;
  assign mod_r[0] = s_r;

  for (genvar j = 0; j < NMOD; j++) begin : g_mod
    pyd_mod_cell #(
      .R_W (SUM_W),
      .SUB (FULL_TURN_S << (NMOD - 1 - j))
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .valid_in  (mod_v[j]),
      .r_in      (mod_r[j]),
      .valid_out (mod_v[j+1]),
      .r_out     (mod_r[j+1])
    );
  end

  // CORDIC row, both lanes side by side
  assign cord_v[0]     = c_v;
  assign cord_yaw[0]   = c_yaw;
  assign cord_pitch[0] = c_pitch;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    pyd_cordic_cell #(
      .STEP (i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .valid_in  (cord_v[i]),
      .yaw_in    (cord_yaw[i]),
      .pitch_in  (cord_pitch[i]),
      .valid_out (cord_v[i+1]),
      .yaw_out   (cord_yaw[i+1]),
      .pitch_out (cord_pitch[i+1])
    );
  end

endmodule

@@ test/tb_pointer_yaw_pitch_direction_top.sv @@
// ----------------------------------------------------------------------------
// tb_pointer_yaw_pitch_direction_top: self-checking bench for the pointer
// yaw/pitch direction block
// Feeds directed and random pointer walks and face front beats under several
// sensitivity and pitch limit settings, with random gaps and stalls on both
// sides. It predicts each direction vector with its own CORDIC and
// compares every output beat field by field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

import pyd_pkg::*;

localparam int VIEW_W  = DEF_DIR_FRAC_BITS + 2;
localparam int COORD_W = DEF_COORD_BITS;

typedef struct packed {
  logic signed [VIEW_W-1:0] x;
  logic signed [VIEW_W-1:0] y;
  logic signed [VIEW_W-1:0] z;
} view_t;

class direction_tracker;
  longint atan_deg[CORDIC_STEPS];
  longint sens, plim, last_x, last_y, yaw, pitch;
  bit     first_pending;
  view_t  views_due[$];
  int     errors, checked, faces, samples;

  function new();
    atan_deg = '{47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658,
                 469357, 234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
                 917, 458, 229, 115};
    sens          = 635;
    plim          = longint'(89) <<< DEF_ANGLE_FRAC_BITS;
    last_x        = 0;
    last_y        = 0;
    first_pending = 1'b1;
    yaw           = longint'(270) <<< DEF_ANGLE_FRAC_BITS;
    pitch         = 0;
  endfunction

  function void set_reg(cfg_reg_t r, longint v);
    case (r)
      REG_SENSITIVITY: sens = v & 'hFFF;
      REG_PITCH_LIMIT: plim = v & 'h1FFFF;
      default: ;
    endcase
  endfunction

  function int pending();
    return views_due.size();
  endfunction

  // angle in 2^-20 degree, cos and sin back in Q30
  function void rotate(longint a, output longint c, output longint s);
    longint half, quarter, x, y, dx, dy;
    bit     flip;
    int     i;
    half    = longint'(180) <<< CORDIC_ANG_FRAC;
    quarter = longint'(90) <<< CORDIC_ANG_FRAC;
    x       = 652032874;
    y       = 0;
    flip    = 1'b0;
    if (a > half) a -= 2 * half;
    if (a <= -half) a += 2 * half;
    // fold the back half-plane onto the front and negate at the end
    if (a > quarter) begin
      a -= half;
      flip = 1'b1;
    end else if (a < -quarter) begin
      a += half;
      flip = 1'b1;
    end
    for (i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (a >= 0) begin
        x -= dx;
        y += dy;
        a -= atan_deg[i];
      end else begin
        x += dx;
        y -= dy;
        a += atan_deg[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function longint narrow(longint v, int shift);
    longint lim;
    lim = longint'(1) <<< DEF_DIR_FRAC_BITS;
    v = (v + (longint'(1) <<< (shift - 1))) >>> shift;
    if (v > lim) v = lim;
    if (v < -lim) v = -lim;
    return v;
  endfunction

  function void take_sample(func_t f, logic signed [COORD_W-1:0] mx,
                            logic signed [COORD_W-1:0] my);
    longint dx, dy, lim, full_turn, scale, cy, sy, cp, sp;
    view_t  v;
    full_turn = longint'(360) <<< DEF_ANGLE_FRAC_BITS;
    scale     = longint'(1) <<< (CORDIC_ANG_FRAC - DEF_ANGLE_FRAC_BITS);
    if (f == FUNC_FACE_FRONT) begin
      yaw   = longint'(270) <<< DEF_ANGLE_FRAC_BITS;
      pitch = 0;
      v.x   = '0;
      v.y   = '0;
      v.z   = VIEW_W'(-(longint'(1) <<< DEF_DIR_FRAC_BITS));
      faces++;
    end else begin
      if (first_pending) begin
        last_x        = longint'(mx);
        last_y        = longint'(my);
        first_pending = 1'b0;
      end
      dx     = longint'(mx) - last_x;
      dy     = last_y - longint'(my);
      last_x = longint'(mx);
      last_y = longint'(my);
      yaw = (yaw + dx * sens) % full_turn;
      if (yaw < 0) yaw += full_turn;
      lim = plim;
      if (lim > (longint'(90) <<< DEF_ANGLE_FRAC_BITS))
        lim = longint'(90) <<< DEF_ANGLE_FRAC_BITS;
      pitch = pitch + dy * sens;
      if (pitch > lim) pitch = lim;
      if (pitch < -lim) pitch = -lim;
      rotate(yaw * scale, cy, sy);
      rotate(pitch * scale, cp, sp);
      v.x = VIEW_W'(narrow(cy * cp, 60 - DEF_DIR_FRAC_BITS));
      v.y = VIEW_W'(narrow(sp, 30 - DEF_DIR_FRAC_BITS));
      v.z = VIEW_W'(narrow(sy * cp, 60 - DEF_DIR_FRAC_BITS));
      samples++;
    end
    views_due.push_back(v);
  endfunction

  function void compare_field(string name, logic signed [VIEW_W-1:0] want,
                              logic signed [VIEW_W-1:0] got);
    if (want !== got) begin
      $display("%0t view_%s mismatch: expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  function void check_view(view_t got);
    view_t want;
    if (views_due.size() == 0) begin
      $display("%0t unexpected beat: expected none, got (%0d, %0d, %0d)",
               $time, got.x, got.y, got.z);
      errors++;
      return;
    end
    want = views_due.pop_front();
    compare_field("x", want.x, got.x);
    compare_field("y", want.y, got.y);
    compare_field("z", want.z, got.z);
    checked++;
  endfunction
endclass

module tb_pointer_yaw_pitch_direction_top;

  localparam int NUM_SETTINGS = 7;
  localparam int BEATS_PER_SETTING = 170;
  localparam longint SENS_SET[NUM_SETTINGS]  = '{635, 4095, 0, 1, 0, 2048, 635};
  localparam longint LIMIT_SET[NUM_SETTINGS] = '{91136, 92160, 0, 46080, 0, 131071, 91136};

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0]      cfg_index = '0;
  logic [CFG_DATA_W-1:0]       cfg_data = '0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic                        func = 1'b0;
  logic signed [COORD_W-1:0]   mouse_x = '0;
  logic signed [COORD_W-1:0]   mouse_y = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic signed [VIEW_W-1:0]    view_x;
  logic signed [VIEW_W-1:0]    view_y;
  logic signed [VIEW_W-1:0]    view_z;

  direction_tracker tracker = new();

  bit                        calm = 1'b0;
  bit                        hold_start = 1'b0;
  int                        hold_left = 0;
  int                        beats_sent = 0;
  logic signed [COORD_W-1:0] cur_x = '0;
  logic signed [COORD_W-1:0] cur_y = '0;

  pointer_yaw_pitch_direction_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .func      (func),
    .mouse_x   (mouse_x),
    .mouse_y   (mouse_y),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .view_x    (view_x),
    .view_y    (view_y),
    .view_z    (view_z)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Output side: check accepted beats, then pick next cycle's stall.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall)
        tracker.check_view('{x: view_x, y: view_y, z: view_z});
      if (hold_start) begin
        hold_left  = 400;
        hold_start = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= (!calm && $urandom_range(99) < 28);
      end
    end
  end

  // Called at a clock edge; leaves valid high after the beat is taken.
  task automatic send_beat(func_t f, logic signed [COORD_W-1:0] x,
                           logic signed [COORD_W-1:0] y);
    int gap;
    if (!calm && $urandom_range(99) < 28) begin
      gap = ($urandom_range(9) == 0) ? $urandom_range(45, 1) : $urandom_range(6, 1);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    func     <= f;
    mouse_x  <= x;
    mouse_y  <= y;
    do @(posedge clk); while (in_stall);
    tracker.take_sample(f, x, y);
    beats_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_registers(longint sens, longint lim);
    cfg_write <= 1'b1;
    cfg_index <= REG_SENSITIVITY;
    cfg_data  <= CFG_DATA_W'(sens);
    @(posedge clk);
    tracker.set_reg(REG_SENSITIVITY, sens);
    cfg_index <= REG_PITCH_LIMIT;
    cfg_data  <= CFG_DATA_W'(lim);
    @(posedge clk);
    tracker.set_reg(REG_PITCH_LIMIT, lim);
    cfg_write <= 1'b0;
  endtask

  // Mostly smooth pointer motion, with jumps, full-range noise and face front.
  task automatic pointer_walk(int count);
    int r;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(99);
      if (r < 8) begin
        send_beat(FUNC_FACE_FRONT, COORD_W'($urandom), COORD_W'($urandom));
      end else begin
        if (r < 14) begin
          cur_x = COORD_W'($urandom);
          cur_y = COORD_W'($urandom);
        end else if (r < 22) begin
          cur_x = cur_x + COORD_W'($urandom_range(4000)) - COORD_W'(2000);
          cur_y = cur_y + COORD_W'($urandom_range(4000)) - COORD_W'(2000);
        end else begin
          cur_x = cur_x + COORD_W'($urandom_range(24)) - COORD_W'(12);
          cur_y = cur_y + COORD_W'($urandom_range(24)) - COORD_W'(12);
        end
        send_beat(FUNC_POINTER, cur_x, cur_y);
      end
    end
  endtask

  initial begin
    #10_000_000;
    $display("tb_pointer_yaw_pitch_direction_top: errors");
    $finish;
  end

  initial begin
    int waited;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    for (int s = 0; s < NUM_SETTINGS; s++) begin
      if (s != 0) wait_drained();
      if (s == 4)
        set_registers($urandom_range(4095), $urandom_range(92160));
      else
        set_registers(SENS_SET[s], LIMIT_SET[s]);
      calm = (s == 5);
      if (s == 0) begin
        // first sample, repeat position, yaw wrap both ways, coordinate extremes
        send_beat(FUNC_POINTER, 16'sd100, -16'sd50);
        send_beat(FUNC_POINTER, 16'sd100, -16'sd50);
        send_beat(FUNC_POINTER, 16'sd112, -16'sd58);
        send_beat(FUNC_FACE_FRONT, -16'sd1, 16'sd32767);
        send_beat(FUNC_POINTER, 16'sd262, -16'sd58);
        send_beat(FUNC_FACE_FRONT, 16'sd0, 16'sd0);
        send_beat(FUNC_POINTER, -16'sd188, -16'sd58);
        send_beat(FUNC_POINTER, 16'sd32767, 16'sd32767);
        send_beat(FUNC_POINTER, -16'sd32768, -16'sd32768);
        send_beat(FUNC_POINTER, -16'sd32768, 16'sd32767);
        send_beat(FUNC_POINTER, 16'sd32767, -16'sd32768);
        send_beat(FUNC_POINTER, 16'sd0, 16'sd0);
        send_beat(FUNC_POINTER, 16'sd0, 16'sd150);
        send_beat(FUNC_POINTER, 16'sd0, -16'sd300);
        send_beat(FUNC_FACE_FRONT, -16'sd32768, -16'sd32768);
        send_beat(FUNC_POINTER, 16'sd1, -16'sd1);
        cur_x = 16'sd1;
        cur_y = -16'sd1;
      end
      pointer_walk(BEATS_PER_SETTING / 2);
      // back up the output while the input keeps offering beats
      if (s == 1) hold_start = 1'b1;
      // let the pipeline run dry before carrying on
      if (s == 3) wait_drained();
      pointer_walk(BEATS_PER_SETTING / 2);
    end
    calm = 1'b0;
    in_valid <= 1'b0;
    for (waited = 0; tracker.pending() != 0 && waited < 5000; waited++) @(posedge clk);
    repeat (60) @(posedge clk);
    if (tracker.pending() != 0) begin
      $display("%0t missing beats: expected %0d more, got none",
               $time, tracker.pending());
      tracker.errors++;
    end
    $display("run covered %0d beats (%0d pointer, %0d face front) over %0d register settings,",
             beats_sent, tracker.samples, tracker.faces, NUM_SETTINGS);
    $display("with one long output hold-off and %0d direction beats compared",
             tracker.checked);
    if (tracker.errors == 0) begin
      $display("tb_pointer_yaw_pitch_direction_top: clean");
    end else begin
      $display("tb_pointer_yaw_pitch_direction_top: errors");
    end
    $finish;
  end

endmodule
